/* rtl/core/humidity_temp_frame_check_convert_assert.svh */
// Assertion macros shared by the frame check/convert RTL.
// Needs nothing else; included by the modules that carry checks.
`ifndef HUMIDITY_TEMP_FRAME_CHECK_CONVERT_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_CHECK_CONVERT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define HTFC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define HTFC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/htfc_pkg.sv */
// Shared types, constants and the CRC-8 byte update for the frame checker.
// No dependencies.
package htfc_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic KIND_HUMIDITY = 1'b0;
  localparam logic KIND_TEMP     = 1'b1;

  localparam logic [7:0]  CRC_POLY_LOW = 8'h31;   // x^8+x^5+x^4+1, top bit implied
  localparam logic [15:0] STATUS_MASK  = 16'hFFFC;
  localparam logic [15:0] RAW_ON_ERROR = 16'h0001;

  localparam logic [14:0] RH_SCALE = 15'd12500;
  localparam logic [14:0] T_SCALE  = 15'd17572;
  localparam logic signed [15:0] RH_OFFSET = -16'sd600;
  localparam logic signed [15:0] T_OFFSET  = -16'sd4685;

  // checked frame, front to back
  typedef struct packed {
    logic [15:0] raw;
    logic        crc_error;
    logic        kind;
  } frame_t;

  // one byte through the MSB-first CRC-8, no reflection
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY_LOW;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/core/htfc_front.sv */
// Front end: byte framing, kind latch and running CRC-8.
// Uses htfc_pkg; pushes one checked frame per third byte.
module htfc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_valid_i,
  input  logic [7:0]        data_byte_i,
  input  logic              measure_kind_i,
  output logic              push_o,
  output htfc_pkg::frame_t  frame_o
);

  localparam logic [1:0] POS_MSB = 2'd0;
  localparam logic [1:0] POS_LSB = 2'd1;
  localparam logic [1:0] POS_CRC = 2'd2;

  logic [1:0] pos_q, pos_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] high_q, high_d;
  logic [7:0] low_q, low_d;
  logic       kind_q, kind_d;
  logic       mismatch;

  assign mismatch = (crc_q != data_byte_i);

  always_comb begin
    pos_d  = pos_q;
    crc_d  = crc_q;
    high_d = high_q;
    low_d  = low_q;
    kind_d = kind_q;
    push_o = 1'b0;
    if (byte_valid_i) begin
      case (pos_q)
        POS_LSB: begin
          low_d = data_byte_i;
          crc_d = htfc_pkg::crc8_byte(crc_q, data_byte_i);
          pos_d = POS_CRC;
        end
        POS_CRC: begin
          push_o = 1'b1;
          crc_d  = 8'h00;
          pos_d  = POS_MSB;
        end
        default: begin
          // new frame; the unused code also restarts here
          high_d = data_byte_i;
          kind_d = measure_kind_i;
          crc_d  = htfc_pkg::crc8_byte(8'h00, data_byte_i);
          pos_d  = POS_LSB;
        end
      endcase
    end
  end

  assign frame_o.crc_error = mismatch;
  assign frame_o.raw       = mismatch ? htfc_pkg::RAW_ON_ERROR : {high_q, low_q};
  assign frame_o.kind      = kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_MSB;
      crc_q <= 8'h00;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    high_q <= high_d;
    low_q  <= low_d;
    kind_q <= kind_d;
  end

endmodule

/* rtl/core/htfc_queue.sv */
// Small register FIFO of checked frames between front and back.
// Uses htfc_pkg and the assertion macro header.
`include "humidity_temp_frame_check_convert_assert.svh"

module htfc_queue #(
  parameter int unsigned DEPTH = htfc_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  htfc_pkg::frame_t  push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output htfc_pkg::frame_t  head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  htfc_pkg::frame_t  mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == FULL_CNT);
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `HTFC_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, count_q <= FULL_CNT, "queue overfilled")
  `HTFC_ASSERT_IMP(a_no_drop, clk_i, rst_ni, push_i, !full_o, "push into full queue")
  `HTFC_ASSERT_NXT(a_cnt_up, clk_i, rst_ni, do_push && !do_pop,
                   count_q == $past(count_q) + 1'b1, "count did not follow push")

endmodule

/* rtl/core/htfc_back.sv */
// Back end: scale/offset conversion and the output register.
// Uses htfc_pkg and the assertion macro header.
`include "humidity_temp_frame_check_convert_assert.svh"

module htfc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              avail_i,
  input  htfc_pkg::frame_t  frame_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [15:0]       raw_value_o,
  output logic              crc_error_o,
  output logic [14:0]       converted_o,
  output logic              result_kind_o
);

  logic              valid_q, valid_d;
  logic [15:0]       raw_q;
  logic              err_q;
  logic [14:0]       conv_q;
  logic              kind_q;
  logic [15:0]       masked;
  logic [14:0]       scale;
  logic [15:0]       offset;
  logic [30:0]       product;
  logic [15:0]       conv_full;

  assign pop_o   = avail_i && (!valid_q || out_ready_i);
  assign valid_d = pop_o || (valid_q && !out_ready_i);

  // floor(scale * m / 65536) + offset
  assign masked    = frame_i.raw & htfc_pkg::STATUS_MASK;
  assign scale     = (frame_i.kind == htfc_pkg::KIND_TEMP) ? htfc_pkg::T_SCALE
                                                           : htfc_pkg::RH_SCALE;
  assign offset    = (frame_i.kind == htfc_pkg::KIND_TEMP) ? htfc_pkg::T_OFFSET
                                                           : htfc_pkg::RH_OFFSET;
  assign product   = 31'(scale) * 31'(masked);
  assign conv_full = offset + {1'b0, product[30:16]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      raw_q  <= frame_i.raw;
      err_q  <= frame_i.crc_error;
      conv_q <= conv_full[14:0];
      kind_q <= frame_i.kind;
    end
  end

  assign out_valid_o   = valid_q;
  assign raw_value_o   = raw_q;
  assign crc_error_o   = err_q;
  assign converted_o   = conv_q;
  assign result_kind_o = kind_q;

  `HTFC_ASSERT_IMP(a_err_raw, clk_i, rst_ni, valid_q && err_q,
                   raw_q == htfc_pkg::RAW_ON_ERROR, "error frame raw not forced")
  `HTFC_ASSERT_IMP(a_err_t_offset, clk_i, rst_ni,
                   valid_q && err_q && (kind_q == htfc_pkg::KIND_TEMP),
                   conv_q == htfc_pkg::T_OFFSET[14:0], "error temp not at offset")
  `HTFC_ASSERT_IMP(a_rh_floor, clk_i, rst_ni,
                   valid_q && (kind_q == htfc_pkg::KIND_HUMIDITY),
                   $signed(conv_q) >= $signed(htfc_pkg::RH_OFFSET[14:0]),
                   "humidity below offset")

endmodule

/* rtl/core/humidity_temp_frame_check_convert.sv */
// Top level of the sensor frame checker/converter.
// Uses htfc_pkg, htfc_front, htfc_queue and htfc_back.
//
//  channel   dir  tdata (low bit up)                          tuser
//  s_axis    in   [7:0] data_byte                             measure_kind
//  m_axis    out  [15:0] raw_value, [16] crc_error,           result_kind
//                 [31:17] converted_hundredths (signed)
//
// One byte transfer per cycle is taken while the queue has room; every third
// byte of a frame yields one result transfer through the queue and the output register.
// The byte framing and CRC-8 update are done in the front stage;
// the conversion (one 15x16 multiply plus offset) fills the output register.
// Reset (rst_ni low, async) puts the framer at the MSB with a zero CRC and
// empties the queue and the output register.
// A stalled m_axis side fills the output register and then the queue
// (QUEUE_DEPTH frames); only then does s_axis_tready_o drop.
module humidity_temp_frame_check_convert #(
  parameter int unsigned QUEUE_DEPTH = htfc_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] measure_kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [15:0] raw_value, [16] crc_error, [31:17] converted
  output logic        m_axis_tuser_o    // [0] result_kind
);

  htfc_pkg::frame_t front_frame;
  htfc_pkg::frame_t head_frame;
  logic             front_push;
  logic             q_full;
  logic             q_empty;
  logic             back_pop;
  logic             byte_xfer;
  logic [15:0]      raw_value;
  logic             crc_error;
  logic [14:0]      converted;

  // the framer only needs queue room on the checksum byte, but holding off
  // every byte while full keeps the ready path trivial
  assign s_axis_tready_o = !q_full;
  assign byte_xfer       = s_axis_tvalid_i && s_axis_tready_o;

  htfc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_valid_i   (byte_xfer),
    .data_byte_i    (s_axis_tdata_i),
    .measure_kind_i (s_axis_tuser_i),
    .push_o         (front_push),
    .frame_o        (front_frame)
  );

  htfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_push),
    .push_data_i (front_frame),
    .full_o      (q_full),
    .pop_i       (back_pop),
    .empty_o     (q_empty),
    .head_o      (head_frame)
  );

  htfc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .avail_i       (!q_empty),
    .frame_i       (head_frame),
    .pop_o         (back_pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .raw_value_o   (raw_value),
    .crc_error_o   (crc_error),
    .converted_o   (converted),
    .result_kind_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {converted, crc_error, raw_value};

endmodule
